// ===== hdl/clx_pkg.sv =====
`timescale 1ns / 1ps

package clx_pkg;

    localparam int KIND_W     = 5;
    localparam int CHAR_W     = 8;
    localparam int LEX_DEPTH  = 16;
    localparam int ADDR_W     = $clog2(LEX_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int LEX_KEEP   = 15;
    localparam int POS_W      = 16;
    localparam int KW_NUM     = 6;

    // token kinds
    localparam logic [KIND_W-1:0] K_END     = 5'd0;
    localparam logic [KIND_W-1:0] K_ERR     = 5'd1;
    localparam logic [KIND_W-1:0] K_IDENT   = 5'd2;
    localparam logic [KIND_W-1:0] K_DEC     = 5'd3;
    localparam logic [KIND_W-1:0] K_HEX     = 5'd4;
    localparam logic [KIND_W-1:0] K_MAIN    = 5'd5;
    localparam logic [KIND_W-1:0] K_SLASH   = 5'd11;
    localparam logic [KIND_W-1:0] K_NE      = 5'd12;
    localparam logic [KIND_W-1:0] K_EQEQ    = 5'd13;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd14;
    localparam logic [KIND_W-1:0] K_LE      = 5'd15;
    localparam logic [KIND_W-1:0] K_LT      = 5'd16;
    localparam logic [KIND_W-1:0] K_GE      = 5'd17;
    localparam logic [KIND_W-1:0] K_GT      = 5'd18;
    localparam logic [KIND_W-1:0] K_INC     = 5'd19;
    localparam logic [KIND_W-1:0] K_PLUS    = 5'd20;
    localparam logic [KIND_W-1:0] K_DECR    = 5'd21;
    localparam logic [KIND_W-1:0] K_MINUS   = 5'd22;
    localparam logic [KIND_W-1:0] K_STAR    = 5'd23;
    localparam logic [KIND_W-1:0] K_PERCENT = 5'd24;
    localparam logic [KIND_W-1:0] K_COMMA   = 5'd25;
    localparam logic [KIND_W-1:0] K_SEMI    = 5'd26;
    localparam logic [KIND_W-1:0] K_LPAREN  = 5'd27;
    localparam logic [KIND_W-1:0] K_RPAREN  = 5'd28;
    localparam logic [KIND_W-1:0] K_LBRACE  = 5'd29;
    localparam logic [KIND_W-1:0] K_RBRACE  = 5'd30;

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_SLASH  = 4'd1,
        M_LINE   = 4'd2,
        M_BLOCK  = 4'd3,
        M_BSTAR  = 4'd4,
        M_IDENT  = 4'd5,
        M_DEC    = 4'd6,
        M_ZERO   = 4'd7,
        M_HEXPRE = 4'd8,
        M_HEX    = 4'd9,
        M_BANG   = 4'd10,
        M_EQ     = 4'd11,
        M_LT     = 4'd12,
        M_GT     = 4'd13,
        M_PLUS   = 4'd14,
        M_MINUS  = 4'd15
    } mode_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_RD,
        E_LD,
        E_SINGLE,
        E_WRITE
    } emit_state_t;

    // what one input byte does
    typedef struct packed {
        logic                flush_en;
        logic [KIND_W-1:0]   flush_kind;
        logic [CNT_W-1:0]    flush_len;
        logic                single_en;
        logic [KIND_W-1:0]   single_kind;
        logic [CHAR_W-1:0]   single_byte;
        logic                wr_en;
        logic                wr_late;
        logic [ADDR_W-1:0]   wr_addr;
        logic [CHAR_W-1:0]   wr_data;
        logic                begin_en;
        mode_t               mode_next;
        logic [CNT_W-1:0]    count_next;
        logic [KW_NUM-1:0]   mask_next;
    } act_t;

endpackage

// ===== hdl/c_subset_lexical_scanner.sv =====
// Flow: a flushed token goes through E_RD (one lexeme RAM read) and E_LD (one output load)
// for each byte, and E_LD waits while the output is stalled; a single-character token is
// loaded from E_SINGLE, and a new token that starts right after a flush passes E_WRITE to
// write its first byte.
// Throughput: a word that gives no result is taken every cycle while idle.
// Reset (aresetn low, synchronous) returns to idle at line 0, column 0; the RAM is not cleared.
`timescale 1ns / 1ps

module c_subset_lexical_scanner (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [clx_pkg::CHAR_W-1:0]        s_char_code,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [clx_pkg::KIND_W-1:0]        m_token_kind,
    output logic [clx_pkg::CHAR_W-1:0]        m_lexeme_byte,
    output logic [clx_pkg::ADDR_W-1:0]        m_byte_index,
    output logic [clx_pkg::POS_W-1:0]         m_token_line,
    output logic [clx_pkg::POS_W-1:0]         m_token_column,
    output logic                              m_token_done,
    output logic                              m_run_last
);
    import clx_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    mode_t             mode_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [KW_NUM-1:0] mask_reg;
    logic [POS_W-1:0]  line_reg, line_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  start_line_reg;
    logic [POS_W-1:0]  start_col_reg;

    act_t act;
    logic emit_idle;
    logic accept;

    assign s_ready = emit_idle;
    assign accept  = s_valid && s_ready;

    clx_decode u_decode (
        .mode  (mode_reg),
        .count (count_reg),
        .mask  (mask_reg),
        .c     (s_char_code),
        .act   (act)
    );

    clx_emit u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (accept),
        .act            (act),
        .tok_line       (start_line_reg),
        .tok_col        (start_col_reg),
        .cur_line       (line_reg),
        .cur_col        (col_reg),
        .idle           (emit_idle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_lexeme_byte  (m_lexeme_byte),
        .m_byte_index   (m_byte_index),
        .m_token_line   (m_token_line),
        .m_token_column (m_token_column),
        .m_token_done   (m_token_done),
        .m_run_last     (m_run_last)
    );

    // saturating position; a zero byte does not advance the column
    always_comb begin
        line_next = line_reg;
        col_next  = col_reg;
        if (s_char_code == "\n") begin
            if (line_reg != POS_MAX) begin
                line_next = line_reg + POS_W'(1);
            end
            col_next = '0;
        end else if (s_char_code != 8'h00) begin
            if (col_reg != POS_MAX) begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= M_IDLE;
            count_reg      <= '0;
            mask_reg       <= '0;
            line_reg       <= '0;
            col_reg        <= '0;
            start_line_reg <= '0;
            start_col_reg  <= '0;
        end else if (accept) begin
            mode_reg  <= act.mode_next;
            count_reg <= act.count_next;
            mask_reg  <= act.mask_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            if (act.begin_en) begin
                start_line_reg <= line_reg;
                start_col_reg  <= col_reg;
            end
        end
    end

endmodule

// ===== hdl/clx_decode.sv =====
`timescale 1ns / 1ps

module clx_decode (
    input  clx_pkg::mode_t                     mode,
    input  logic [clx_pkg::CNT_W-1:0]          count,
    input  logic [clx_pkg::KW_NUM-1:0]         mask,
    input  logic [clx_pkg::CHAR_W-1:0]         c,
    output clx_pkg::act_t                      act
);
    import clx_pkg::*;

    localparam int KW_MAXLEN = 6;
    localparam logic [CHAR_W-1:0] KW_TEXT [KW_NUM][KW_MAXLEN] = '{
        '{"m", "a", "i", "n", 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "s", "t", 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"l", "o", "n", "g", 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n"}
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd4, 3'd3, 3'd5, 3'd3, 3'd4, 3'd6};

    function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
    endfunction

    function automatic logic is_hexd(input logic [CHAR_W-1:0] ch);
        return is_digit(ch) || (ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F");
    endfunction

    logic              do_app;
    logic              do_idle;
    logic              fl_req;
    logic [KIND_W-1:0] fl_kind;
    logic [KIND_W-1:0] id_kind;
    logic [KW_NUM-1:0] app_mask;
    logic [KW_NUM-1:0] init_mask;
    logic              multi_en;
    mode_t             multi_mode;
    logic              one_en;
    logic [KIND_W-1:0] one_kind;
    logic [CHAR_W-1:0] one_byte;

    // keyword candidates: match on the kept bytes and the exact length
    always_comb begin
        id_kind = K_IDENT;
        for (int j = KW_NUM - 1; j >= 0; j--) begin
            app_mask[j]  = (count < CNT_W'(KW_LEN[j])) && (KW_TEXT[j][count[2:0]] == c);
            init_mask[j] = (KW_TEXT[j][0] == c);
            if (mask[j] && count == CNT_W'(KW_LEN[j])) begin
                id_kind = K_MAIN + KIND_W'(j);
            end
        end
    end

    // what a byte does between tokens
    always_comb begin
        multi_en   = 1'b0;
        multi_mode = M_IDLE;
        one_en     = 1'b0;
        one_kind   = K_ERR;
        one_byte   = c;
        case (c)
            " ", "\t", "\n": begin
            end
            8'h00: begin
                one_en   = 1'b1;
                one_kind = K_END;
                one_byte = "#";
            end
            "/": begin multi_en = 1'b1; multi_mode = M_SLASH; end
            "!": begin multi_en = 1'b1; multi_mode = M_BANG;  end
            "=": begin multi_en = 1'b1; multi_mode = M_EQ;    end
            "<": begin multi_en = 1'b1; multi_mode = M_LT;    end
            ">": begin multi_en = 1'b1; multi_mode = M_GT;    end
            "+": begin multi_en = 1'b1; multi_mode = M_PLUS;  end
            "-": begin multi_en = 1'b1; multi_mode = M_MINUS; end
            "*": begin one_en = 1'b1; one_kind = K_STAR;    end
            "%": begin one_en = 1'b1; one_kind = K_PERCENT; end
            ",": begin one_en = 1'b1; one_kind = K_COMMA;   end
            ";": begin one_en = 1'b1; one_kind = K_SEMI;    end
            "(": begin one_en = 1'b1; one_kind = K_LPAREN;  end
            ")": begin one_en = 1'b1; one_kind = K_RPAREN;  end
            "{": begin one_en = 1'b1; one_kind = K_LBRACE;  end
            "}": begin one_en = 1'b1; one_kind = K_RBRACE;  end
            default: begin
                if (c == "0") begin
                    multi_en = 1'b1; multi_mode = M_ZERO;
                end else if (is_digit(c)) begin
                    multi_en = 1'b1; multi_mode = M_DEC;
                end else if (is_alpha(c)) begin
                    multi_en = 1'b1; multi_mode = M_IDENT;
                end else begin
                    one_en = 1'b1; one_kind = K_ERR;
                end
            end
        endcase
    end

    always_comb begin
        act            = '0;
        act.mode_next  = mode;
        act.count_next = count;
        act.mask_next  = mask;
        do_app         = 1'b0;
        do_idle        = 1'b0;
        fl_req         = 1'b0;
        fl_kind        = K_ERR;

        case (mode)
            M_SLASH: begin
                if (c == "/") begin
                    act.mode_next = M_LINE;
                end else if (c == "*") begin
                    act.mode_next = M_BLOCK;
                end else begin
                    fl_req = 1'b1; fl_kind = K_SLASH; do_idle = 1'b1;
                end
            end
            M_LINE: begin
                if (c == 8'h00) begin
                    do_idle = 1'b1;
                end else if (c == "\n") begin
                    act.mode_next = M_IDLE;
                end
            end
            M_BLOCK: begin
                if (c == 8'h00) begin
                    do_idle = 1'b1;
                end else if (c == "*") begin
                    act.mode_next = M_BSTAR;
                end
            end
            M_BSTAR: begin
                if (c == 8'h00) begin
                    do_idle = 1'b1;
                end else if (c == "/") begin
                    act.mode_next = M_IDLE;
                end else if (c != "*") begin
                    act.mode_next = M_BLOCK;
                end
            end
            M_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    do_app = 1'b1;
                end else begin
                    fl_req = 1'b1; fl_kind = id_kind; do_idle = 1'b1;
                end
            end
            M_DEC: begin
                if (is_digit(c)) begin
                    do_app = 1'b1;
                end else begin
                    fl_req = 1'b1; fl_kind = K_DEC; do_idle = 1'b1;
                end
            end
            M_ZERO: begin
                if (c == "x") begin
                    do_app = 1'b1; act.mode_next = M_HEXPRE;
                end else if (is_digit(c)) begin
                    do_app = 1'b1; act.mode_next = M_DEC;
                end else begin
                    fl_req = 1'b1; fl_kind = K_DEC; do_idle = 1'b1;
                end
            end
            M_HEXPRE: begin
                if (is_hexd(c)) begin
                    do_app = 1'b1; act.mode_next = M_HEX;
                end else begin
                    // swallow the offending byte unless it ends the text
                    fl_req = 1'b1; fl_kind = K_ERR; do_idle = (c == 8'h00);
                end
            end
            M_HEX: begin
                if (is_hexd(c)) begin
                    do_app = 1'b1;
                end else begin
                    fl_req = 1'b1; fl_kind = K_HEX; do_idle = 1'b1;
                end
            end
            M_BANG: begin
                if (c == "=") begin
                    do_app = 1'b1; fl_req = 1'b1; fl_kind = K_NE;
                end else begin
                    fl_req = 1'b1; fl_kind = K_ERR; do_idle = 1'b1;
                end
            end
            M_EQ: begin
                if (c == "=") begin
                    do_app = 1'b1; fl_req = 1'b1; fl_kind = K_EQEQ;
                end else begin
                    fl_req = 1'b1; fl_kind = K_ASSIGN; do_idle = 1'b1;
                end
            end
            M_LT: begin
                if (c == "=") begin
                    do_app = 1'b1; fl_req = 1'b1; fl_kind = K_LE;
                end else begin
                    fl_req = 1'b1; fl_kind = K_LT; do_idle = 1'b1;
                end
            end
            M_GT: begin
                if (c == "=") begin
                    do_app = 1'b1; fl_req = 1'b1; fl_kind = K_GE;
                end else begin
                    fl_req = 1'b1; fl_kind = K_GT; do_idle = 1'b1;
                end
            end
            M_PLUS: begin
                if (c == "+") begin
                    do_app = 1'b1; fl_req = 1'b1; fl_kind = K_INC;
                end else begin
                    fl_req = 1'b1; fl_kind = K_PLUS; do_idle = 1'b1;
                end
            end
            M_MINUS: begin
                if (c == "-") begin
                    do_app = 1'b1; fl_req = 1'b1; fl_kind = K_DECR;
                end else begin
                    fl_req = 1'b1; fl_kind = K_MINUS; do_idle = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // drop bytes past the kept length
        if (do_app && count < CNT_W'(LEX_KEEP)) begin
            act.wr_en      = 1'b1;
            act.wr_addr    = count[ADDR_W-1:0];
            act.wr_data    = c;
            act.count_next = count + CNT_W'(1);
            act.mask_next  = mask & app_mask;
        end

        if (fl_req) begin
            act.flush_en   = 1'b1;
            act.flush_kind = fl_kind;
            act.flush_len  = act.count_next;
            act.count_next = '0;
            act.mode_next  = M_IDLE;
        end

        if (do_idle) begin
            act.mode_next = M_IDLE;
            if (multi_en) begin
                act.begin_en   = 1'b1;
                act.wr_en      = 1'b1;
                // the pending lexeme must be read out before slot zero is reused
                act.wr_late    = act.flush_en;
                act.wr_addr    = '0;
                act.wr_data    = c;
                act.count_next = CNT_W'(1);
                act.mask_next  = init_mask;
                act.mode_next  = multi_mode;
            end else if (one_en) begin
                act.begin_en    = 1'b1;
                act.single_en   = 1'b1;
                act.single_kind = one_kind;
                act.single_byte = one_byte;
                act.count_next  = '0;
            end
        end
    end

endmodule

// ===== hdl/clx_emit.sv =====
`timescale 1ns / 1ps

module clx_emit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  clx_pkg::act_t                     act,
    input  logic [clx_pkg::POS_W-1:0]         tok_line,
    input  logic [clx_pkg::POS_W-1:0]         tok_col,
    input  logic [clx_pkg::POS_W-1:0]         cur_line,
    input  logic [clx_pkg::POS_W-1:0]         cur_col,
    output logic                              idle,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [clx_pkg::KIND_W-1:0]        m_token_kind,
    output logic [clx_pkg::CHAR_W-1:0]        m_lexeme_byte,
    output logic [clx_pkg::ADDR_W-1:0]        m_byte_index,
    output logic [clx_pkg::POS_W-1:0]         m_token_line,
    output logic [clx_pkg::POS_W-1:0]         m_token_column,
    output logic                              m_token_done,
    output logic                              m_run_last
);
    import clx_pkg::*;

    logic [CHAR_W-1:0] mem [LEX_DEPTH];

    emit_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CHAR_W-1:0] rd_data_reg;

    logic [KIND_W-1:0] fl_kind_reg;
    logic [CNT_W-1:0]  fl_len_reg;
    logic [POS_W-1:0]  fl_line_reg;
    logic [POS_W-1:0]  fl_col_reg;
    logic              sg_en_reg;
    logic [KIND_W-1:0] sg_kind_reg;
    logic [CHAR_W-1:0] sg_byte_reg;
    logic [POS_W-1:0]  sg_line_reg;
    logic [POS_W-1:0]  sg_col_reg;
    logic              lw_en_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    logic [CHAR_W-1:0] lw_data_reg;

    logic              m_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [CHAR_W-1:0] byte_reg;
    logic [ADDR_W-1:0] index_reg;
    logic [POS_W-1:0]  line_reg;
    logic [POS_W-1:0]  col_reg;
    logic              done_reg;
    logic              last_reg;

    logic              out_free;
    logic              last_byte;
    logic              load_fl;
    logic              load_sg;
    logic              mem_rd;
    logic              lw_do;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CHAR_W-1:0] mem_wd;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_byte = (CNT_W'(idx_reg) + CNT_W'(1)) == fl_len_reg;
    assign idle      = (state_reg == E_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        load_fl    = 1'b0;
        load_sg    = 1'b0;
        mem_rd     = 1'b0;
        lw_do      = 1'b0;
        case (state_reg)
            E_IDLE: begin
                idx_next = '0;
                if (start) begin
                    if (act.flush_en) begin
                        state_next = E_RD;
                    end else if (act.single_en) begin
                        state_next = E_SINGLE;
                    end
                end
            end
            E_RD: begin
                mem_rd     = 1'b1;
                state_next = E_LD;
            end
            E_LD: begin
                if (out_free) begin
                    load_fl = 1'b1;
                    if (last_byte) begin
                        if (sg_en_reg) begin
                            state_next = E_SINGLE;
                        end else if (lw_en_reg) begin
                            state_next = E_WRITE;
                        end else begin
                            state_next = E_IDLE;
                        end
                    end else begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = E_RD;
                    end
                end
            end
            E_SINGLE: begin
                if (out_free) begin
                    load_sg    = 1'b1;
                    state_next = lw_en_reg ? E_WRITE : E_IDLE;
                end
            end
            E_WRITE: begin
                lw_do      = 1'b1;
                state_next = E_IDLE;
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_we = lw_do || (start && act.wr_en && !act.wr_late);
        mem_wa = lw_do ? lw_addr_reg : act.wr_addr;
        mem_wd = lw_do ? lw_data_reg : act.wr_data;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_rd) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // hold the work of one input byte
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (start) begin
            fl_kind_reg <= act.flush_kind;
            fl_len_reg  <= act.flush_len;
            fl_line_reg <= tok_line;
            fl_col_reg  <= tok_col;
            sg_kind_reg <= act.single_kind;
            sg_byte_reg <= act.single_byte;
            sg_line_reg <= cur_line;
            sg_col_reg  <= cur_col;
            lw_addr_reg <= act.wr_addr;
            lw_data_reg <= act.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sg_en_reg <= 1'b0;
            lw_en_reg <= 1'b0;
        end else if (start) begin
            sg_en_reg <= act.single_en;
            lw_en_reg <= act.wr_en && act.wr_late;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_fl || load_sg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_fl) begin
            kind_reg  <= fl_kind_reg;
            byte_reg  <= rd_data_reg;
            index_reg <= idx_reg;
            line_reg  <= fl_line_reg;
            col_reg   <= fl_col_reg;
            done_reg  <= last_byte;
            last_reg  <= last_byte && !sg_en_reg;
        end else if (load_sg) begin
            kind_reg  <= sg_kind_reg;
            byte_reg  <= sg_byte_reg;
            index_reg <= '0;
            line_reg  <= sg_line_reg;
            col_reg   <= sg_col_reg;
            done_reg  <= 1'b1;
            last_reg  <= 1'b1;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_token_kind   = kind_reg;
    assign m_lexeme_byte  = byte_reg;
    assign m_byte_index   = index_reg;
    assign m_token_line   = line_reg;
    assign m_token_column = col_reg;
    assign m_token_done   = done_reg;
    assign m_run_last     = last_reg;

endmodule

// ===== hdl/clx_checker.sv =====
`timescale 1ns / 1ps

module clx_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [clx_pkg::KIND_W-1:0]        m_token_kind,
    input  logic [clx_pkg::CHAR_W-1:0]        m_lexeme_byte,
    input  logic [clx_pkg::ADDR_W-1:0]        m_byte_index,
    input  logic                              m_token_done,
    input  logic                              m_run_last
);
    import clx_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind)
            && $stable(m_lexeme_byte) && $stable(m_byte_index))
        else $error("result word changed while stalled");

    a_last_ends_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_last |-> m_token_done)
        else $error("run ends inside a token");

    a_end_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == K_END |->
            m_lexeme_byte == "#" && m_byte_index == '0 && m_token_done)
        else $error("malformed end token");

    a_single_punct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind >= K_STAR |-> m_byte_index == '0 && m_token_done)
        else $error("single-character token longer than one byte");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_token_done ##1 m_valid |->
            m_byte_index == $past(m_byte_index) + 4'd1)
        else $error("lexeme byte index did not advance");

endmodule

bind c_subset_lexical_scanner clx_checker u_clx_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_token_kind  (m_token_kind),
    .m_lexeme_byte (m_lexeme_byte),
    .m_byte_index  (m_byte_index),
    .m_token_done  (m_token_done),
    .m_run_last    (m_run_last)
);
